>>> rtl/pth_sensor_compensation_core_assert.svh
// Assertion macros shared by the checker of the compensation core.
`ifndef PTH_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define PTH_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// Implication in the same cycle, disabled while reset is high.
`define PSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psc core assertion failed");

// Implication in the next cycle, disabled while reset is high.
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psc core assertion failed");

// Condition checked at every clock edge, reset included.
`define PSC_ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) \
    else $error("psc core assertion failed");

`endif

>>> rtl/psc_pkg.sv
// Package with payload types, register indexes and constants of the compensation core.
`timescale 1ns / 1ps

package psc_pkg;

  // One raw sample triple.
  typedef struct packed {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } sample_t;

  // One compensated result.
  typedef struct packed {
    logic signed [31:0] fine_temp;
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
  } result_t;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_WORD  = 3'd4;

  // Pipeline depth and divider shape.
  localparam int LATENCY = 84;
  localparam int DIV_W = 64;

  // Formula constants.
  localparam logic signed [63:0] FINE_P_OFFSET = 64'sd128000;
  localparam logic signed [63:0] PRESS_BASE    = 64'sd1048576;
  localparam logic signed [63:0] PRESS_SCALE   = 64'sd3125;
  localparam logic signed [63:0] P1_BIAS       = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] HUM_OFFSET    = 32'sd76800;
  localparam logic signed [31:0] HUM_MAX       = 32'sd419430400;
  localparam logic signed [31:0] HUM_BIAS      = 32'sd2097152;
  localparam logic signed [31:0] HUM_ROUND     = 32'sd16384;
  localparam logic [16:0]        HUM_Q10_MAX   = 17'd102400;

endpackage

>>> rtl/psc_delay.sv
// Enabled shift line that carries a value a fixed number of pipeline stages.
`timescale 1ns / 1ps

module psc_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [0:D-1];

  // Shift the line one stage whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < D; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[D-1];

endmodule

>>> rtl/psc_mul64.sv
// Two-stage multiplier that gives the low 64 bits of a 64 by 64 product.
`timescale 1ns / 1ps

module psc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);

  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;

  // First stage: three 32 by 32 partial products; the high by high term drops out.
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= 64'(a[31:0]) * 64'(b[31:0]);
      p_lh <= a[31:0] * b[63:32];
      p_hl <= a[63:32] * b[31:0];
    end
  end

  // Second stage: fold the cross terms into the upper word.
  always_ff @(posedge clk) begin
    if (en) begin
      y <= p_ll + {p_lh + p_hl, 32'd0};
    end
  end

endmodule

>>> rtl/psc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
`timescale 1ns / 1ps

module psc_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [psc_pkg::DIV_W-1:0] num,
  input  logic [psc_pkg::DIV_W-1:0] den,
  output logic [psc_pkg::DIV_W-1:0] quo,
  output logic                     zero
);

  localparam int W = psc_pkg::DIV_W;

  logic [W-1:0] rem   [0:W];
  logic [W-1:0] dvd   [0:W];
  logic [W-1:0] dsr   [0:W];
  logic         neg_q [0:W];
  logic         zero_q[0:W];
  logic [W:0]   trial [0:W-1];
  logic [W:0]   diff  [0:W-1];

  // Entry stage: magnitudes, result sign and the zero divisor flag.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= '0;
      dvd[0]    <= num[W-1] ? (~num + 1'b1) : num;
      dsr[0]    <= den[W-1] ? (~den + 1'b1) : den;
      neg_q[0]  <= num[W-1] ^ den[W-1];
      zero_q[0] <= (den == '0);
    end
  end

  // Trial subtraction of each stage.
  always_comb begin
    for (int k = 0; k < W; k++) begin
      trial[k] = {rem[k], dvd[k][W-1]};
      diff[k]  = trial[k] - {1'b0, dsr[k]};
    end
  end

  // Restoring steps; quotient bits shift into the dividend word.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        if (!diff[k][W]) begin
          rem[k+1] <= diff[k][W-1:0];
          dvd[k+1] <= {dvd[k][W-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[k][W-1:0];
          dvd[k+1] <= {dvd[k][W-2:0], 1'b0};
        end
        dsr[k+1]    <= dsr[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // Exit stage: apply the sign of the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      quo  <= neg_q[W] ? (~dvd[W] + 1'b1) : dvd[W];
      zero <= zero_q[W];
    end
  end

endmodule

>>> rtl/pth_sensor_compensation_core.sv
// Top level of the pressure, temperature and humidity compensation pipeline.
`timescale 1ns / 1ps
//
//  Channel  | Signals                         | Direction | Transfer when
//  ---------+---------------------------------+-----------+-----------------------------
//  sample   | sample_valid, sample_stall, sample | in     | sample_valid && !sample_stall
//  result   | result_valid, result_stall, result | out    | result_valid && !result_stall
//  config   | wr_en, wr_index, wr_data        | in        | wr_en
//
//  One sample is taken every cycle while sample_stall is low.
//  The depth is set by the pressure divider and the two-stage 64-bit multipliers.
//  Reset clears the stage valid bits and the trim registers; payload stages are not reset.
//  A stalled result freezes the whole pipeline, so sample_stall follows result_stall
//  whenever a result is waiting; bubbles keep moving otherwise.

module pth_sensor_compensation_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  psc_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output psc_pkg::result_t                result,
  input  logic                            wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]  wr_data
);

  localparam int LAT = psc_pkg::LATENCY;

  // Trim registers.
  logic [63:0] trim_a;
  logic [63:0] trim_b;
  logic [63:0] trim_c;
  logic [7:0]  hum_first;
  logic [55:0] hum_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_a    <= '0;
      trim_b    <= '0;
      trim_c    <= '0;
      hum_first <= '0;
      hum_word  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        psc_pkg::REG_TRIM_A:    trim_a    <= wr_data;
        psc_pkg::REG_TRIM_B:    trim_b    <= wr_data;
        psc_pkg::REG_TRIM_C:    trim_c    <= wr_data;
        psc_pkg::REG_HUM_FIRST: hum_first <= wr_data[7:0];
        psc_pkg::REG_HUM_WORD:  hum_word  <= wr_data[55:0];
        default: ;
      endcase
    end
  end

  // Coefficients unpacked from the trim bytes.
  logic signed [31:0] t1_32, t2_32, t3_32;
  logic signed [31:0] h1_32, h2_32, h3_32, h4_32, h5_32, h6_32;
  logic signed [63:0] p1_64, p2_64, p3_64, p4_64, p5_64, p6_64, p7_64, p8_64, p9_64;

  assign t1_32 = $signed({16'd0, trim_a[15:0]});
  assign t2_32 = 32'($signed(trim_a[31:16]));
  assign t3_32 = 32'($signed(trim_a[47:32]));
  assign p1_64 = $signed({48'd0, trim_a[63:48]});
  assign p2_64 = 64'($signed(trim_b[15:0]));
  assign p3_64 = 64'($signed(trim_b[31:16]));
  assign p4_64 = 64'($signed(trim_b[47:32]));
  assign p5_64 = 64'($signed(trim_b[63:48]));
  assign p6_64 = 64'($signed(trim_c[15:0]));
  assign p7_64 = 64'($signed(trim_c[31:16]));
  assign p8_64 = 64'($signed(trim_c[47:32]));
  assign p9_64 = 64'($signed(trim_c[63:48]));
  assign h1_32 = $signed({24'd0, hum_first});
  assign h2_32 = 32'($signed(hum_word[15:0]));
  assign h3_32 = $signed({24'd0, hum_word[23:16]});
  assign h4_32 = 32'($signed({hum_word[31:24], hum_word[35:32]}));
  assign h5_32 = 32'($signed({hum_word[47:40], hum_word[39:36]}));
  assign h6_32 = 32'($signed(hum_word[55:48]));

  // Pipeline advance and stage valid bits.
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], sample_valid};
    end
  end

  // Stage registers, named by the stage whose output they are.
  logic signed [31:0] a3_s1, d_s1, m1_s2, dd_s2, v1_s3, q_s3, fine_s4, temp_s5;
  logic signed [31:0] hx_s5, hbase_s5, hbase_s6, hm5_s6, hm6_s6, hm3_s6;
  logic signed [31:0] ha_s7, hb1_s7, hc_s7, hbb_s8, hb2_s9, hb3_s10, hb4_s11;
  logic signed [31:0] hxx_s12, hxx_s13, hxx_s14, hxx_s15, ha2_s13, haa_s14, hs_s15;
  logic signed [31:0] hd, hcl;
  logic [16:0]        hum_s16;
  logic signed [63:0] v_s5, v2_s10, v1b_s10, np_s11, vd_s13;
  logic [15:0]        ah_s4;
  logic [19:0]        ap_s10;
  logic signed [31:0] ha_s11;

  // Temperature and the front of the pressure and humidity paths.
  always_ff @(posedge clk) begin
    if (adv) begin
      a3_s1    <= $signed({15'd0, sample.adc_temp[19:3]}) -
                  $signed({15'd0, t1_32[15:0], 1'b0});
      d_s1     <= $signed({16'd0, sample.adc_temp[19:4]}) - t1_32;
      m1_s2    <= a3_s1 * t2_32;
      dd_s2    <= d_s1 * d_s1;
      v1_s3    <= m1_s2 >>> 11;
      q_s3     <= (dd_s2 >>> 12) * t3_32;
      fine_s4  <= v1_s3 + (q_s3 >>> 14);
      temp_s5  <= (fine_s4 <<< 2) + fine_s4 + 32'sd128;
      v_s5     <= 64'(fine_s4) - psc_pkg::FINE_P_OFFSET;
      hx_s5    <= fine_s4 - psc_pkg::HUM_OFFSET;
      hbase_s5 <= ($signed({16'd0, ah_s4}) <<< 14) - (h4_32 <<< 20);
    end
  end

  // Humidity stages, at most one multiply per stage on each branch.
  always_ff @(posedge clk) begin
    if (adv) begin
      hbase_s6 <= hbase_s5;
      hm5_s6   <= h5_32 * hx_s5;
      hm6_s6   <= hx_s5 * h6_32;
      hm3_s6   <= hx_s5 * h3_32;
      ha_s7    <= (hbase_s6 - hm5_s6 + psc_pkg::HUM_ROUND) >>> 15;
      hb1_s7   <= hm6_s6 >>> 10;
      hc_s7    <= (hm3_s6 >>> 11) + 32'sd32768;
      hbb_s8   <= hb1_s7 * hc_s7;
      hb2_s9   <= (hbb_s8 >>> 10) + psc_pkg::HUM_BIAS;
      hb3_s10  <= hb2_s9 * h2_32;
      hb4_s11  <= (hb3_s10 + 32'sd8192) >>> 14;
      hxx_s12  <= ha_s11 * hb4_s11;
      ha2_s13  <= hxx_s12 >>> 15;
      hxx_s13  <= hxx_s12;
      haa_s14  <= ha2_s13 * ha2_s13;
      hxx_s14  <= hxx_s13;
      hs_s15   <= (haa_s14 >>> 7) * h1_32;
      hxx_s15  <= hxx_s14;
      hum_s16  <= hcl[28:12];
    end
  end

  // Humidity clamp before the final shift.
  always_comb begin
    hd = hxx_s15 - (hs_s15 >>> 4);
    if (hd < 0) begin
      hcl = '0;
    end else if (hd > psc_pkg::HUM_MAX) begin
      hcl = psc_pkg::HUM_MAX;
    end else begin
      hcl = hd;
    end
  end

  psc_delay #(.W(16), .D(4)) u_dly_ah (
    .clk(clk), .en(adv), .d(sample.adc_hum), .q(ah_s4));
  psc_delay #(.W(20), .D(10)) u_dly_ap (
    .clk(clk), .en(adv), .d(sample.adc_press), .q(ap_s10));
  psc_delay #(.W(32), .D(4)) u_dly_ha (
    .clk(clk), .en(adv), .d(ha_s7), .q(ha_s11));

  // Pressure divisor and dividend.
  logic signed [63:0] vv_s7, vp5_s7, vp2_s7, vp5_s9, vp2_s9, v2a_s9, v1a_s9;
  logic signed [63:0] v1c_s12, num_s13;

  psc_mul64 u_mul_vv  (.clk(clk), .en(adv), .a(v_s5),  .b(v_s5),  .y(vv_s7));
  psc_mul64 u_mul_vp5 (.clk(clk), .en(adv), .a(v_s5),  .b(p5_64), .y(vp5_s7));
  psc_mul64 u_mul_vp2 (.clk(clk), .en(adv), .a(v_s5),  .b(p2_64), .y(vp2_s7));
  psc_mul64 u_mul_vp6 (.clk(clk), .en(adv), .a(vv_s7), .b(p6_64), .y(v2a_s9));
  psc_mul64 u_mul_vp3 (.clk(clk), .en(adv), .a(vv_s7), .b(p3_64), .y(v1a_s9));

  psc_delay #(.W(64), .D(2)) u_dly_vp5 (
    .clk(clk), .en(adv), .d(vp5_s7), .q(vp5_s9));
  psc_delay #(.W(64), .D(2)) u_dly_vp2 (
    .clk(clk), .en(adv), .d(vp2_s7), .q(vp2_s9));

  always_ff @(posedge clk) begin
    if (adv) begin
      v2_s10  <= v2a_s9 + (vp5_s9 <<< 17) + (p4_64 <<< 35);
      v1b_s10 <= (v1a_s9 >>> 8) + (vp2_s9 <<< 12) + psc_pkg::P1_BIAS;
      np_s11  <= ((psc_pkg::PRESS_BASE - $signed({44'd0, ap_s10})) <<< 31) - v2_s10;
      vd_s13  <= v1c_s12 >>> 33;
    end
  end

  psc_mul64 u_mul_p1 (.clk(clk), .en(adv), .a(v1b_s10), .b(p1_64), .y(v1c_s12));
  psc_mul64 u_mul_sc (.clk(clk), .en(adv), .a(np_s11), .b(psc_pkg::PRESS_SCALE),
                      .y(num_s13));

  // Division and the pressure correction terms.
  logic signed [63:0] quo_s79, ps_s79, ps_s81, t_s81, j_s81, t2_s83, j_s83, quo_s83;
  logic signed [63:0] pf;
  logic               zero_s79, zero_s83;

  psc_div u_div (
    .clk(clk), .en(adv), .num(num_s13), .den(vd_s13), .quo(quo_s79), .zero(zero_s79));

  assign ps_s79 = quo_s79 >>> 13;

  psc_mul64 u_mul_p9 (.clk(clk), .en(adv), .a(p9_64), .b(ps_s79),  .y(t_s81));
  psc_mul64 u_mul_p8 (.clk(clk), .en(adv), .a(p8_64), .b(quo_s79), .y(j_s81));
  psc_mul64 u_mul_sq (.clk(clk), .en(adv), .a(t_s81), .b(ps_s81),  .y(t2_s83));

  psc_delay #(.W(64), .D(2)) u_dly_ps (
    .clk(clk), .en(adv), .d(ps_s79), .q(ps_s81));
  psc_delay #(.W(64), .D(2)) u_dly_j (
    .clk(clk), .en(adv), .d(j_s81), .q(j_s83));
  psc_delay #(.W(64), .D(4)) u_dly_quo (
    .clk(clk), .en(adv), .d(quo_s79), .q(quo_s83));
  psc_delay #(.W(1), .D(4)) u_dly_zero (
    .clk(clk), .en(adv), .d(zero_s79), .q(zero_s83));

  assign pf = ((quo_s83 + (t2_s83 >>> 25) + (j_s83 >>> 19)) >>> 8) + (p7_64 <<< 4);

  // Early results wait for the pressure path.
  logic signed [31:0] fine_s83, temp_s83;
  logic [16:0]        hum_s83;

  psc_delay #(.W(32), .D(79)) u_dly_fine (
    .clk(clk), .en(adv), .d(fine_s4), .q(fine_s83));
  psc_delay #(.W(32), .D(78)) u_dly_temp (
    .clk(clk), .en(adv), .d(temp_s5), .q(temp_s83));
  psc_delay #(.W(17), .D(67)) u_dly_hum (
    .clk(clk), .en(adv), .d(hum_s16), .q(hum_s83));

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      result.fine_temp   <= fine_s83;
      result.temperature <= temp_s83;
      result.pressure    <= zero_s83 ? 32'd0 : pf[31:0];
      result.humidity    <= hum_s83;
    end
  end

endmodule

>>> rtl/psc_checker.sv
// Port-level checker of the compensation core and its bind statement.
`timescale 1ns / 1ps
`include "pth_sensor_compensation_core_assert.svh"

module psc_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input psc_pkg::result_t result
);

  // A waiting result holds until its transfer.
  `PSC_ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

  // The input side stalls exactly when a result is held back.
  `PSC_ASSERT_IMPLY(a_stall, clk, rst, sample_valid || !sample_valid, sample_stall == (result_valid && result_stall))

  // No result is shown right after reset.
  `PSC_ASSERT_ALWAYS(a_reset, clk, rst || !$past(rst) || !result_valid)

  // Temperature is always derived from the fine temperature of the same result.
  `PSC_ASSERT_IMPLY(a_temp, clk, rst, result_valid, result.temperature == (result.fine_temp * 5 + 128))

  // Humidity never exceeds the clamp.
  `PSC_ASSERT_IMPLY(a_hum, clk, rst, result_valid, result.humidity <= psc_pkg::HUM_Q10_MAX)

endmodule

bind pth_sensor_compensation_core psc_checker u_checker (
  .clk(clk),
  .rst(rst),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result(result)
);
